### hdl/ysb_pkg.sv
// Shared types and constants for the subsampled YCbCr line to BGR converter.
// No dependencies.
`timescale 1ns / 1ps

package ysb_pkg;

	typedef logic [7:0] sample_t;

	// One group as the back end needs it: own chroma, neighbours' chroma, lumas
	typedef struct packed {
		sample_t [3:0] luma;
		sample_t       prev_cr;
		sample_t       cb;
		sample_t       cr;
		sample_t       next_cb;
		sample_t       next_cr;
		logic          last;
		logic          mode;
	} job_t;

	localparam logic MODE_422 = 1'b0;
	localparam logic MODE_411 = 1'b1;

	localparam int unsigned REG_FORMAT_MODE = 0;

	// BT.601 integer matrix
	localparam logic signed [19:0] K_Y  = 20'sd298;
	localparam logic signed [19:0] K_BU = 20'sd516;
	localparam logic signed [19:0] K_GU = 20'sd100;
	localparam logic signed [19:0] K_GV = 20'sd208;
	localparam logic signed [19:0] K_RV = 20'sd409;

endpackage

### hdl/ysb_front.sv
// Front end: takes groups, holds one group back for chroma look-ahead and
// issues group jobs to the queue. Depends on ysb_pkg.
`timescale 1ns / 1ps

module ysb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mode,
	input  logic              in_valid,
	output logic              in_ready,
	input  ysb_pkg::sample_t  chroma_u,
	input  ysb_pkg::sample_t  chroma_v,
	input  ysb_pkg::sample_t  luma_a,
	input  ysb_pkg::sample_t  luma_b,
	input  ysb_pkg::sample_t  luma_c,
	input  ysb_pkg::sample_t  luma_d,
	input  logic              last_group,
	output logic              push_valid,
	input  logic              push_ready,
	output ysb_pkg::job_t     push_job
);

	logic                        held_q;
	ysb_pkg::sample_t            held_cb_q;
	ysb_pkg::sample_t            held_cr_q;
	ysb_pkg::sample_t [3:0]      held_y_q;
	ysb_pkg::sample_t            earlier_cr_q;
	logic                        pend_valid_q;
	ysb_pkg::job_t               pend_job_q;

	logic                        accept;
	ysb_pkg::sample_t            ecr_new;
	ysb_pkg::job_t               job_held;
	ysb_pkg::job_t               job_last;

	assign in_ready = !pend_valid_q && push_ready;
	assign accept   = in_valid && in_ready;
	assign ecr_new  = held_q ? held_cr_q : chroma_v;

	always_comb begin
		job_held.luma    = held_y_q;
		job_held.prev_cr = earlier_cr_q;
		job_held.cb      = held_cb_q;
		job_held.cr      = held_cr_q;
		job_held.next_cb = chroma_u;
		job_held.next_cr = chroma_v;
		job_held.last    = 1'b0;
		job_held.mode    = mode;

		job_last.luma    = {luma_d, luma_c, luma_b, luma_a};
		job_last.prev_cr = ecr_new;
		job_last.cb      = chroma_u;
		job_last.cr      = chroma_v;
		job_last.next_cb = chroma_u;
		job_last.next_cr = chroma_v;
		job_last.last    = 1'b1;
		job_last.mode    = mode;
	end

	// a line's last group arriving behind a held one needs a second slot
	assign push_valid = pend_valid_q || (accept && (held_q || last_group));

	always_comb begin
		if (pend_valid_q) begin
			push_job = pend_job_q;
		end else if (held_q) begin
			push_job = job_held;
		end else begin
			push_job = job_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			earlier_cr_q <= '0;
		end else begin
			if (pend_valid_q && push_ready) begin
				pend_valid_q <= 1'b0;
			end
			if (accept) begin
				earlier_cr_q <= ecr_new;
				if (last_group) begin
					held_q <= 1'b0;
					if (held_q) begin
						pend_valid_q <= 1'b1;
					end
				end else begin
					held_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_job_q <= job_last;
			if (!last_group) begin
				held_cb_q <= chroma_u;
				held_cr_q <= chroma_v;
				held_y_q  <= {luma_d, luma_c, luma_b, luma_a};
			end
		end
	end

endmodule

### hdl/ysb_fifo.sv
// Short job queue between front and back end.
// Depends on ysb_pkg.
`timescale 1ns / 1ps

module ysb_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  ysb_pkg::job_t push_job,
	output logic          head_valid,
	input  logic          pop,
	output ysb_pkg::job_t head_job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	ysb_pkg::job_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_wr      = push_valid && push_ready;
	assign do_rd      = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### hdl/ysb_back.sv
// Back end: walks the pixels of each group job, interpolates chroma and
// runs the BT.601 matrix through a short pipeline. Depends on ysb_pkg.
`timescale 1ns / 1ps

module ysb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  ysb_pkg::job_t     head_job,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output ysb_pkg::sample_t  blue,
	output ysb_pkg::sample_t  green,
	output ysb_pkg::sample_t  red,
	output logic              line_end
);

	function automatic ysb_pkg::sample_t clamp_px(input logic signed [19:0] x);
		logic signed [19:0] sh;
		sh = x >>> 8;
		if (sh < 0) begin
			return 8'd0;
		end else if (sh > 20'sd255) begin
			return 8'd255;
		end
		return sh[7:0];
	endfunction

	logic                 en;
	logic [1:0]           idx_q;
	logic [1:0]           idx_max;
	logic                 grp_done;

	ysb_pkg::sample_t     sel_y;
	ysb_pkg::sample_t     sel_cb;
	ysb_pkg::sample_t     sel_cr;

	logic                 valid_s1;
	ysb_pkg::sample_t     y_s1;
	ysb_pkg::sample_t     cb_s1;
	ysb_pkg::sample_t     cr_s1;
	logic                 end_s1;

	logic                 valid_s2;
	logic signed [19:0]   ty_s2;
	logic signed [19:0]   bu_s2;
	logic signed [19:0]   gu_s2;
	logic signed [19:0]   gv_s2;
	logic signed [19:0]   rv_s2;
	logic                 end_s2;

	logic                 out_valid_q;
	ysb_pkg::sample_t     blue_q;
	ysb_pkg::sample_t     green_q;
	ysb_pkg::sample_t     red_q;
	logic                 line_end_q;

	logic signed [9:0]    y_off;
	logic signed [9:0]    cb_off;
	logic signed [9:0]    cr_off;

	ysb_pkg::sample_t     u0;
	ysb_pkg::sample_t     v0;
	ysb_pkg::sample_t     un;
	ysb_pkg::sample_t     vn;
	ysb_pkg::sample_t     pv;
	logic [9:0]           u3;
	logic [9:0]           un3;
	logic [9:0]           v3;

	// whole pipeline advances together; output register holds while stalled
	assign en       = !out_valid_q || out_ready;
	assign idx_max  = (head_job.mode == ysb_pkg::MODE_411) ? 2'd3 : 2'd1;
	assign grp_done = (idx_q == idx_max);
	assign pop      = en && head_valid && grp_done;

	assign u0  = head_job.cb;
	assign v0  = head_job.cr;
	assign un  = head_job.next_cb;
	assign vn  = head_job.next_cr;
	assign pv  = head_job.prev_cr;
	assign u3  = {1'b0, u0, 1'b0} + {2'b00, u0};
	assign un3 = {1'b0, un, 1'b0} + {2'b00, un};
	assign v3  = {1'b0, v0, 1'b0} + {2'b00, v0};

	always_comb begin
		sel_y  = head_job.luma[idx_q];
		sel_cb = u0;
		sel_cr = v0;
		if (head_job.mode == ysb_pkg::MODE_422) begin
			if (idx_q == 2'd0) begin
				if (head_job.last) begin
					sel_cr = 8'({1'b0, pv[7:1]} + {1'b0, v0[7:1]});
				end else begin
					sel_cr = 8'(({1'b0, pv} + {1'b0, v0}) >> 1);
				end
			end else if (!head_job.last) begin
				sel_cb = 8'(({1'b0, u0} + {1'b0, un}) >> 1);
			end
		end else begin
			case (idx_q)
				2'd0: begin
					sel_cr = 8'({1'b0, pv[7:1]} + {1'b0, v0[7:1]});
				end
				2'd1: begin
					sel_cb = 8'({1'b0, u3[9:2]} + {3'b000, un[7:2]});
					sel_cr = 8'({3'b000, pv[7:2]} + {1'b0, v3[9:2]});
				end
				2'd2: begin
					sel_cb = 8'({1'b0, u0[7:1]} + {1'b0, un[7:1]});
				end
				default: begin
					sel_cb = 8'({3'b000, u0[7:2]} + {1'b0, un3[9:2]});
					sel_cr = 8'({1'b0, v3[9:2]} + {3'b000, vn[7:2]});
				end
			endcase
		end
	end

	assign y_off  = signed'({2'b00, y_s1})  - 10'sd16;
	assign cb_off = signed'({2'b00, cb_s1}) - 10'sd128;
	assign cr_off = signed'({2'b00, cr_s1}) - 10'sd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= head_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
			if (head_valid) begin
				idx_q <= grp_done ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1   <= sel_y;
			cb_s1  <= sel_cb;
			cr_s1  <= sel_cr;
			end_s1 <= head_job.last && grp_done;

			ty_s2  <= 20'(y_off)  * ysb_pkg::K_Y;
			bu_s2  <= 20'(cb_off) * ysb_pkg::K_BU;
			gu_s2  <= 20'(cb_off) * ysb_pkg::K_GU;
			gv_s2  <= 20'(cr_off) * ysb_pkg::K_GV;
			rv_s2  <= 20'(cr_off) * ysb_pkg::K_RV;
			end_s2 <= end_s1;

			blue_q     <= clamp_px(ty_s2 + bu_s2);
			green_q    <= clamp_px(ty_s2 - gu_s2 - gv_s2);
			red_q      <= clamp_px(ty_s2 + rv_s2);
			line_end_q <= end_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign blue      = blue_q;
	assign green     = green_q;
	assign red       = red_q;
	assign line_end  = line_end_q;

endmodule

### hdl/yuv_subsampled_to_bgr_line.sv
// Flow: a group's pixels come after the item that releases it is taken (its successor,
// or the group itself when it ends a line), through the queue, stages s1, s2 and the output
// register; behind a flushed held group a line's last group follows that group's pixels.
// Throughput: one pixel per cycle from the back end unless out_ready stalls it,
// so 2 pixels per 4:2:2 item and 4 per 4:1:1 item; a flush of two groups gives twice that.
// Reset: asynchronous; clears the held group, the queue and the pipeline, mode 4:2:2.
`timescale 1ns / 1ps

module yuv_subsampled_to_bgr_line #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  ysb_pkg::sample_t  chroma_u,
	input  ysb_pkg::sample_t  chroma_v,
	input  ysb_pkg::sample_t  luma_a,
	input  ysb_pkg::sample_t  luma_b,
	input  ysb_pkg::sample_t  luma_c,
	input  ysb_pkg::sample_t  luma_d,
	input  logic              last_group,
	output logic              out_valid,
	input  logic              out_ready,
	output ysb_pkg::sample_t  blue,
	output ysb_pkg::sample_t  green,
	output ysb_pkg::sample_t  red,
	output logic              line_end
);

	logic           format_mode_q;
	logic           reg_hit;
	logic           push_valid;
	logic           push_ready;
	ysb_pkg::job_t  push_job;
	logic           head_valid;
	logic           pop;
	ysb_pkg::job_t  head_job;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == 1'(ysb_pkg::REG_FORMAT_MODE));
	assign prdata  = reg_hit ? {31'd0, format_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= ysb_pkg::MODE_422;
		end else if (psel && penable && pwrite && reg_hit) begin
			format_mode_q <= pwdata[0];
		end
	end

	ysb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (format_mode_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.chroma_u   (chroma_u),
		.chroma_v   (chroma_v),
		.luma_a     (luma_a),
		.luma_b     (luma_b),
		.luma_c     (luma_c),
		.luma_d     (luma_d),
		.last_group (last_group),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	ysb_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.head_valid (head_valid),
		.pop        (pop),
		.head_job   (head_job)
	);

	ysb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.blue       (blue),
		.green      (green),
		.red        (red),
		.line_end   (line_end)
	);

endmodule

### tb/tb_top.sv
// Self-checking bench for yuv_subsampled_to_bgr_line: directed and random groups in
// 4:2:2 and 4:1:1, each output pixel checked against a BT.601 predictor.
// Depends on ysb_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		ysb_pkg::sample_t       cb;
		ysb_pkg::sample_t       cr;
		ysb_pkg::sample_t [3:0] luma;
		logic                   last;
	} group_t;

	typedef struct packed {
		ysb_pkg::sample_t blue;
		ysb_pkg::sample_t green;
		ysb_pkg::sample_t red;
		logic             line_end;
	} pixel_t;

	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_STALL  = 300;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [2:0]       paddr = '0;
	logic [31:0]      pwdata = '0;
	logic [31:0]      prdata;
	logic             pready;
	logic             in_valid = 1'b0;
	logic             in_ready;
	ysb_pkg::sample_t chroma_u = '0;
	ysb_pkg::sample_t chroma_v = '0;
	ysb_pkg::sample_t luma_a = '0;
	ysb_pkg::sample_t luma_b = '0;
	ysb_pkg::sample_t luma_c = '0;
	ysb_pkg::sample_t luma_d = '0;
	logic             last_group = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	ysb_pkg::sample_t blue;
	ysb_pkg::sample_t green;
	ysb_pkg::sample_t red;
	logic             line_end;

	yuv_subsampled_to_bgr_line u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.chroma_u   (chroma_u),
		.chroma_v   (chroma_v),
		.luma_a     (luma_a),
		.luma_b     (luma_b),
		.luma_c     (luma_c),
		.luma_d     (luma_d),
		.last_group (last_group),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.blue       (blue),
		.green      (green),
		.red        (red),
		.line_end   (line_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Predictor state
	logic        fmt_mode = ysb_pkg::MODE_422;
	logic        have_held = 1'b0;
	group_t      held_grp;
	int unsigned prior_cr = 0;
	pixel_t      pixels_due [$];

	group_t      groups_to_send [$];
	group_t      on_offer;
	int          send_gap = 0;
	int          stall_left = 0;
	bit          idling = 1'b1;
	bit          long_stall_req = 1'b0;
	int          n_errors = 0;
	int          quiet_cycles = 0;
	pixel_t      want_px;

	function automatic ysb_pkg::sample_t clamp8(int x);
		if (x < 0)
			return 8'd0;
		if (x > 255)
			return 8'd255;
		return ysb_pkg::sample_t'(x);
	endfunction

	function automatic void push_pixel(ysb_pkg::sample_t y, int unsigned u, int unsigned v,
			logic eol);
		int     cb;
		int     cr;
		int     ty;
		pixel_t px;
		cb = int'(u) - 128;
		cr = int'(v) - 128;
		ty = 298 * (int'(y) - 16);
		px.blue     = clamp8((ty + 516 * cb) >>> 8);
		px.green    = clamp8((ty - 100 * cb - 208 * cr) >>> 8);
		px.red      = clamp8((ty + 409 * cr) >>> 8);
		px.line_end = eol;
		pixels_due.push_back(px);
	endfunction

	// pv: Cr of the group before; nu/nv: chroma of the group after
	function automatic void emit_group(group_t g, int unsigned pv, int unsigned nu,
			int unsigned nv, logic last);
		int unsigned u;
		int unsigned v;
		u = g.cb;
		v = g.cr;
		if (fmt_mode == ysb_pkg::MODE_422) begin
			if (last) begin
				push_pixel(g.luma[0], u, pv / 2 + v / 2, 1'b0);
				push_pixel(g.luma[1], u, v, 1'b1);
			end else begin
				push_pixel(g.luma[0], u, (pv + v) / 2, 1'b0);
				push_pixel(g.luma[1], (u + nu) / 2, v, 1'b0);
			end
		end else begin
			if (last) begin
				nu = u;
				nv = v;
			end
			push_pixel(g.luma[0], u, pv / 2 + v / 2, 1'b0);
			push_pixel(g.luma[1], (u * 3) / 4 + nu / 4, pv / 4 + (v * 3) / 4, 1'b0);
			push_pixel(g.luma[2], u / 2 + nu / 2, v, 1'b0);
			push_pixel(g.luma[3], u / 4 + (nu * 3) / 4, (v * 3) / 4 + nv / 4, last);
		end
	endfunction

	function automatic void predict_group(group_t g);
		if (have_held) begin
			emit_group(held_grp, prior_cr, g.cb, g.cr, 1'b0);
			prior_cr = held_grp.cr;
		end else begin
			// first group of a line: its own Cr stands in for the earlier one
			prior_cr = g.cr;
		end
		if (g.last) begin
			emit_group(g, prior_cr, g.cb, g.cr, 1'b1);
			have_held = 1'b0;
		end else begin
			have_held = 1'b1;
			held_grp = g;
		end
	endfunction

	// Input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_group(on_offer);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (groups_to_send.size() > 0) begin
					on_offer = groups_to_send.pop_front();
					chroma_u   <= on_offer.cb;
					chroma_v   <= on_offer.cr;
					luma_a     <= on_offer.luma[0];
					luma_b     <= on_offer.luma[1];
					luma_c     <= on_offer.luma[2];
					luma_d     <= on_offer.luma[3];
					last_group <= on_offer.last;
					in_valid   <= 1'b1;
					if (idling && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 19);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor and receiver back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pixels_due.size() == 0) begin
					n_errors++;
					$display("%0t: expected no pixel, actual b=%0d g=%0d r=%0d end=%0b",
						$time, blue, green, red, line_end);
				end else begin
					want_px = pixels_due.pop_front();
					if (blue !== want_px.blue || green !== want_px.green ||
							red !== want_px.red || line_end !== want_px.line_end) begin
						n_errors++;
						$display("%0t: expected %0d/%0d/%0d/%0b, actual %0d/%0d/%0d/%0b",
							$time, want_px.blue, want_px.green, want_px.red,
							want_px.line_end, blue, green, red, line_end);
					end
				end
			end
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				stall_left = LONG_STALL - 1;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idling && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: no item moved on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: watchdog expired, %0d pixels outstanding", $time,
					pixels_due.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic queue_group(input ysb_pkg::sample_t cb, input ysb_pkg::sample_t cr,
			input ysb_pkg::sample_t ya, input ysb_pkg::sample_t yb,
			input ysb_pkg::sample_t yc, input ysb_pkg::sample_t yd, input logic last);
		group_t g;
		g.cb = cb;
		g.cr = cr;
		g.luma[0] = ya;
		g.luma[1] = yb;
		g.luma[2] = yc;
		g.luma[3] = yd;
		g.last = last;
		groups_to_send.push_back(g);
	endtask

	function automatic ysb_pkg::sample_t rand_sample();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return ysb_pkg::sample_t'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly whole lines; now and then a group with a random last flag
	task automatic queue_random(input int n);
		int count;
		int len;
		int k;
		count = 0;
		while (count < n) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_group(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
					rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
				count++;
			end else begin
				len = $urandom_range(1, 6);
				for (k = 0; k < len; k++)
					queue_group(rand_sample(), rand_sample(), rand_sample(),
						rand_sample(), rand_sample(), rand_sample(), k == len - 1);
				count += len;
			end
		end
	endtask

	// Waits until every queued group is sent and every predicted pixel is out, then lets the pipeline settle
	task automatic drain();
		@(negedge clk);
		while (groups_to_send.size() > 0 || in_valid || pixels_due.size() > 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic cfg_write(input int unsigned idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(idx * 4);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == ysb_pkg::REG_FORMAT_MODE)
			fmt_mode = val[0];
		// read back
		@(posedge clk);
		psel    <= 1'b1;
		paddr   <= 3'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[0] !== val[0]) begin
			n_errors++;
			$display("%0t: register %0d readback: expected %0d, actual %0d", $time, idx,
				val[0], prdata[0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int ph;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 4:2:2 from reset: single-group lines at the extremes, short lines
		queue_group(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		queue_group(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		queue_group(8'd0, 8'd255, 8'd16, 8'd235, 8'd7, 8'd200, 1'b0);
		queue_group(8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
		queue_group(8'd128, 8'd128, 8'd128, 8'd64, 8'd1, 8'd2, 1'b1);
		queue_group(8'd255, 8'd255, 8'd0, 8'd255, 8'd170, 8'd85, 1'b0);
		queue_group(8'd0, 8'd0, 8'd255, 8'd0, 8'd85, 8'd170, 1'b1);
		// held group crosses the mode change
		queue_group(8'd200, 8'd50, 8'd90, 8'd180, 8'd33, 8'd66, 1'b0);
		drain();
		cfg_write(ysb_pkg::REG_FORMAT_MODE, 32'(ysb_pkg::MODE_411));

		// flush of the held group plus a last group: eight pixels from one item
		queue_group(8'd10, 8'd240, 8'd100, 8'd110, 8'd120, 8'd130, 1'b1);
		queue_group(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		queue_group(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		queue_group(8'd255, 8'd0, 8'd0, 8'd85, 8'd170, 8'd255, 1'b0);
		queue_group(8'd0, 8'd255, 8'd255, 8'd170, 8'd85, 8'd0, 1'b0);
		queue_group(8'd3, 8'd252, 8'd16, 8'd235, 8'd16, 8'd235, 1'b0);
		queue_group(8'd252, 8'd3, 8'd240, 8'd15, 8'd240, 8'd15, 1'b1);
		queue_group(8'd77, 8'd177, 8'd12, 8'd34, 8'd56, 8'd78, 1'b0);
		drain();
		cfg_write(ysb_pkg::REG_FORMAT_MODE, 32'(ysb_pkg::MODE_422));

		queue_group(8'd177, 8'd77, 8'd200, 8'd201, 8'd202, 8'd203, 1'b1);
		queue_group(8'd1, 8'd254, 8'd1, 8'd254, 8'd1, 8'd254, 1'b0);
		queue_group(8'd254, 8'd1, 8'd254, 8'd1, 8'd254, 8'd1, 1'b1);
		drain();

		for (ph = 0; ph < 6; ph++) begin
			if (ph == 0)
				long_stall_req = 1'b1;
			if (ph == 5)
				idling = 1'b0;
			queue_random(65);
			if (ph == 5)
				queue_group(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
					rand_sample(), rand_sample(), 1'b1);
			drain();
			if (ph < 5)
				cfg_write(ysb_pkg::REG_FORMAT_MODE, 32'(~fmt_mode));
		end

		repeat (20) @(posedge clk);
		if (n_errors == 0 && pixels_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
